/* rtl/assert_macros.svh */
// Assertion helpers clocked on the block clock, muted during reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Holds on every clock edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// Implication checked on every clock edge outside reset.
`define ASSERT_IMPL(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* rtl/spilcd_pkg.sv */
package spilcd_pkg;

   localparam int unsigned CSR_INDEX_W = 3;
   localparam int unsigned CSR_DATA_W  = 16;

   localparam logic [CSR_INDEX_W-1:0] CSR_COLUMN_SET   = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_ROW_SET      = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_MEMORY_WRITE = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_ROW_END_COL  = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_ROW_END_ROW  = 3'd4;

   localparam logic [7:0]  RESET_COLUMN_SET   = 8'd42;
   localparam logic [7:0]  RESET_ROW_SET      = 8'd43;
   localparam logic [7:0]  RESET_MEMORY_WRITE = 8'd44;
   localparam logic [15:0] RESET_ROW_END_COL  = 16'd320;
   localparam logic [15:0] RESET_ROW_END_ROW  = 16'd240;

   localparam logic [2:0] MODE_WINDOW    = 3'd0;
   localparam logic [2:0] MODE_PUSH      = 3'd1;
   localparam logic [2:0] MODE_DRAW      = 3'd2;
   localparam logic [2:0] MODE_ROW_START = 3'd3;
   localparam logic [2:0] MODE_RAW_CMD   = 3'd4;
   localparam logic [2:0] MODE_RAW_DATA  = 3'd5;

   // byte positions of the output sequence
   typedef logic [3:0] pos_type;
   localparam pos_type POS_COL_CMD = 4'd0;
   localparam pos_type POS_X0_HI   = 4'd1;
   localparam pos_type POS_X0_LO   = 4'd2;
   localparam pos_type POS_X1_HI   = 4'd3;
   localparam pos_type POS_X1_LO   = 4'd4;
   localparam pos_type POS_ROW_CMD = 4'd5;
   localparam pos_type POS_Y0_HI   = 4'd6;
   localparam pos_type POS_Y0_LO   = 4'd7;
   localparam pos_type POS_Y1_HI   = 4'd8;
   localparam pos_type POS_Y1_LO   = 4'd9;
   localparam pos_type POS_MEM_CMD = 4'd10;
   localparam pos_type POS_PIX_HI  = 4'd11;
   localparam pos_type POS_PIX_LO  = 4'd12;
   localparam pos_type POS_RAW     = 4'd13;

   function automatic logic [15:0] pack565(input logic [23:0] rgb);
      pack565 = {rgb[23:19], rgb[15:10], rgb[7:3]};
   endfunction

endpackage

/* rtl/spi_lcd_window_pixel_streamer.sv */
// channel   direction  handshake              payload
// req       in         req_valid / req_stall  mode, x/y start and end, rgb, raw byte
// rsp       out        rsp_valid / rsp_stall  spi_byte, is_data, cs_release, last
// csr       in         csr_write              csr_index, csr_data
//
// One byte leaves per cycle unless rsp_stall holds the output: 2 bytes for a pixel push,
// 11 for a window or row start, 13 for a draw pixel, 1 for a raw byte; the byte sequencer sets the rate.
// A new request is taken in the cycle the previous one issues its last byte.
// Reset is synchronous and restores the command codes and row end registers.
// rsp_stall holds the output register and, through it, the request side.
`include "assert_macros.svh"

module spi_lcd_window_pixel_streamer (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic [2:0]                           req_mode,
   input  logic [15:0]                          req_x_start,
   input  logic [15:0]                          req_y_start,
   input  logic [15:0]                          req_x_end,
   input  logic [15:0]                          req_y_end,
   input  logic [23:0]                          req_rgb,
   input  logic [7:0]                           req_raw_byte,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [7:0]                           rsp_spi_byte,
   output logic                                 rsp_is_data,
   output logic                                 rsp_cs_release,
   output logic                                 rsp_last,
   input  logic                                 csr_write,
   input  logic [spilcd_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [spilcd_pkg::CSR_DATA_W-1:0]    csr_data
);

   logic [7:0]  col_code_ff, row_code_ff, mem_code_ff;
   logic [15:0] row_end_col_ff, row_end_row_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         col_code_ff    <= spilcd_pkg::RESET_COLUMN_SET;
         row_code_ff    <= spilcd_pkg::RESET_ROW_SET;
         mem_code_ff    <= spilcd_pkg::RESET_MEMORY_WRITE;
         row_end_col_ff <= spilcd_pkg::RESET_ROW_END_COL;
         row_end_row_ff <= spilcd_pkg::RESET_ROW_END_ROW;
      end else if (csr_write) begin
         case (csr_index)
            spilcd_pkg::CSR_COLUMN_SET:   col_code_ff    <= csr_data[7:0];
            spilcd_pkg::CSR_ROW_SET:      row_code_ff    <= csr_data[7:0];
            spilcd_pkg::CSR_MEMORY_WRITE: mem_code_ff    <= csr_data[7:0];
            spilcd_pkg::CSR_ROW_END_COL:  row_end_col_ff <= csr_data;
            spilcd_pkg::CSR_ROW_END_ROW:  row_end_row_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // request register: current transaction being sequenced
   logic                   item_valid_ff, item_valid_in;
   spilcd_pkg::pos_type    idx_ff, idx_in;
   spilcd_pkg::pos_type    end_ff, end_in;
   logic [15:0]            x0_ff, y0_ff, x1_ff, y1_ff;
   logic [15:0]            x1_in, y1_in;
   logic [15:0]            pix_ff;
   logic [7:0]             raw_ff;
   logic                   raw_data_ff;

   logic out_take, emit, item_done, req_take, mode_ok;
   spilcd_pkg::pos_type start_pos;

   assign out_take  = !rsp_valid || !rsp_stall;
   assign emit      = item_valid_ff && out_take;
   assign item_done = emit && (idx_ff == end_ff);
   assign req_stall = item_valid_ff && !item_done;
   assign req_take  = req_valid && !req_stall;

   always_comb begin
      mode_ok   = 1'b1;
      start_pos = spilcd_pkg::POS_COL_CMD;
      end_in    = spilcd_pkg::POS_MEM_CMD;
      x1_in     = req_x_end;
      y1_in     = req_y_end;
      case (req_mode)
         spilcd_pkg::MODE_WINDOW: ;
         spilcd_pkg::MODE_PUSH: begin
            start_pos = spilcd_pkg::POS_PIX_HI;
            end_in    = spilcd_pkg::POS_PIX_LO;
         end
         spilcd_pkg::MODE_DRAW: begin
            end_in = spilcd_pkg::POS_PIX_LO;
            x1_in  = req_x_start + 16'd1;
            y1_in  = req_y_start + 16'd1;
         end
         spilcd_pkg::MODE_ROW_START: begin
            x1_in = row_end_col_ff;
            y1_in = row_end_row_ff;
         end
         spilcd_pkg::MODE_RAW_CMD, spilcd_pkg::MODE_RAW_DATA: begin
            start_pos = spilcd_pkg::POS_RAW;
            end_in    = spilcd_pkg::POS_RAW;
         end
         default: mode_ok = 1'b0;
      endcase

      item_valid_in = item_valid_ff && !item_done;
      idx_in        = emit ? idx_ff + 4'd1 : idx_ff;
      if (req_take) begin
         item_valid_in = mode_ok;
         idx_in        = start_pos;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
      end else begin
         item_valid_ff <= item_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff <= idx_in;
      if (req_take) begin
         end_ff      <= end_in;
         x0_ff       <= req_x_start;
         y0_ff       <= req_y_start;
         x1_ff       <= x1_in;
         y1_ff       <= y1_in;
         pix_ff      <= spilcd_pkg::pack565(req_rgb);
         raw_ff      <= req_raw_byte;
         raw_data_ff <= (req_mode == spilcd_pkg::MODE_RAW_DATA);
      end
   end

   // byte selection
   logic [7:0] byte_sel;
   logic       data_sel, rel_sel;

   always_comb begin
      data_sel = 1'b1;
      rel_sel  = 1'b1;
      case (idx_ff)
         spilcd_pkg::POS_COL_CMD: begin byte_sel = col_code_ff; data_sel = 1'b0; end
         spilcd_pkg::POS_X0_HI:   byte_sel = x0_ff[15:8];
         spilcd_pkg::POS_X0_LO:   byte_sel = x0_ff[7:0];
         spilcd_pkg::POS_X1_HI:   byte_sel = x1_ff[15:8];
         spilcd_pkg::POS_X1_LO:   byte_sel = x1_ff[7:0];
         spilcd_pkg::POS_ROW_CMD: begin byte_sel = row_code_ff; data_sel = 1'b0; end
         spilcd_pkg::POS_Y0_HI:   byte_sel = y0_ff[15:8];
         spilcd_pkg::POS_Y0_LO:   byte_sel = y0_ff[7:0];
         spilcd_pkg::POS_Y1_HI:   byte_sel = y1_ff[15:8];
         spilcd_pkg::POS_Y1_LO:   byte_sel = y1_ff[7:0];
         spilcd_pkg::POS_MEM_CMD: begin byte_sel = mem_code_ff; data_sel = 1'b0; end
         spilcd_pkg::POS_PIX_HI:  begin byte_sel = pix_ff[15:8]; rel_sel = 1'b0; end
         spilcd_pkg::POS_PIX_LO:  byte_sel = pix_ff[7:0];
         spilcd_pkg::POS_RAW:     begin byte_sel = raw_ff; data_sel = raw_data_ff; end
         default:                 byte_sel = raw_ff;
      endcase
   end

   // output register
   logic       rsp_valid_ff;
   logic [7:0] rsp_byte_ff;
   logic       rsp_data_ff, rsp_rel_ff, rsp_last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_take) begin
         rsp_valid_ff <= emit;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         rsp_byte_ff <= byte_sel;
         rsp_data_ff <= data_sel;
         rsp_rel_ff  <= rel_sel;
         rsp_last_ff <= (idx_ff == end_ff);
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_spi_byte   = rsp_byte_ff;
   assign rsp_is_data    = rsp_data_ff;
   assign rsp_cs_release = rsp_rel_ff;
   assign rsp_last       = rsp_last_ff;

   `ASSERT_IMPL(a_idx_in_range, item_valid_ff, idx_ff <= end_ff, "sequence index past end")
   `ASSERT_CLK(a_pix_cs, idx_ff != spilcd_pkg::POS_PIX_HI || !rel_sel, "cs released in pixel")
   `ASSERT_NEXT(a_next_byte, rsp_valid && !rsp_stall && !rsp_last, rsp_valid, "gap in byte run")

endmodule
